[rtl/archimedean_spiral_generator_macros.svh]
// Assertion shorthands for the spiral generator.
// Each expects clk and rst_n in scope.
`ifndef ARCHIMEDEAN_SPIRAL_GENERATOR_MACROS_SVH
`define ARCHIMEDEAN_SPIRAL_GENERATOR_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ASG_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, checked outside reset
`define ASG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

[rtl/asg_pkg.sv]
package asg_pkg;

    // Defaults for the top-level parameters
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int INDEX_WIDTH_DEF   = 16;

    // Configuration register indexes
    localparam int CFG_INDEX_WIDTH = 2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_START_RADIUS = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RADIUS_STEP  = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ANGLE_STEP   = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_POINT_COUNT  = 2'd3;

    // Register reset values
    localparam logic [31:0] START_RADIUS_RST = 32'd16777216;
    localparam logic [23:0] RADIUS_STEP_RST  = 24'd8389;
    localparam logic [31:0] ANGLE_STEP_RST   = 32'd536871;
    localparam logic [16:0] POINT_COUNT_RST  = 17'd32768;

    // round(2^30 / K), K the CORDIC gain limit
    localparam logic [29:0] GAIN_INV = 30'd652032874;

    // Micro-rotation angles, full turn = 2^32
    localparam int ATAN_LEN   = 30;
    localparam int ATAN_IDX_W = 5;
    localparam logic [31:0] ATAN_TURNS [ATAN_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    // Handshake between the sequencer and the rotation unit
    typedef struct packed {
        logic start;
        logic ack;
    } asg_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } asg_sts_t;

    // One finished point, signed Q7.16
    typedef struct packed {
        logic [23:0] y;
        logic [23:0] x;
    } asg_point_t;

endpackage

[rtl/archimedean_spiral_generator.sv]
// Channel   | Direction | Payload
// ----------+-----------+--------------------------------------------------
// s_axis    | in        | tdata[0] restart
// m_axis    | out       | tdata x_coord, y_coord, point_index; tlast last
// cfg       | in        | cfg_index register, cfg_data value
//
// A point passes from acceptance through ST_START, the quarter-turn pre-rotation, the CORDIC_STAGES
// micro-rotations, one per cycle, and C_HOLD into the output register; the next point is taken after C_HOLD.
// s_axis_tready is high only while no point is in work; cfg_ready is always high.
// A result waits in the output register; the next point may be accepted meanwhile.
// rst_n clears control state and loads the register defaults asynchronously.
`include "archimedean_spiral_generator_macros.svh"

module archimedean_spiral_generator #(
    parameter int CORDIC_STAGES = asg_pkg::CORDIC_STAGES_DEF,
    parameter int INDEX_WIDTH   = asg_pkg::INDEX_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // s_axis_tdata: [0] restart, [7:1] zero
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,
    // m_axis_tdata: [23:0] x_coord, [47:24] y_coord, [63:48] point_index
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [63:0]                         m_axis_tdata,
    output logic                                m_axis_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [asg_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [31:0]                         cfg_data
);
    import asg_pkg::*;

    localparam int IW = INDEX_WIDTH;
    localparam int CW = (IW + 1 > 17) ? IW + 1 : 17;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;

    logic [31:0]   start_radius_reg;
    logic [23:0]   radius_step_reg;
    logic [31:0]   angle_step_reg;
    logic [16:0]   point_count_reg;

    logic [1:0]    state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [31:0]   radius_acc_reg, radius_acc_next;
    logic [31:0]   angle_acc_reg, angle_acc_next;
    logic          m_valid_reg, m_valid_next;
    logic [63:0]   m_data_reg, m_data_next;
    logic          m_last_reg, m_last_next;

    asg_cmd_t      cordic_cmd;
    asg_sts_t      cordic_sts;
    asg_point_t    cordic_point;

    logic          in_xact;
    logic          fin_write;
    logic          last_pt;
    logic [CW-1:0] count_ext;
    logic [CW-1:0] count_lim;
    logic [CW-1:0] count_eff;
    logic [CW-1:0] idx_plus;
    logic [IW+15:0] idx_wide;
    logic [32:0]   radius_sum;

    asg_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cordic_cmd),
        .radius (radius_acc_reg),
        .phase  (angle_acc_reg),
        .sts    (cordic_sts),
        .point  (cordic_point)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xact       = s_axis_tvalid && s_axis_tready;
    assign fin_write     = (state_reg == ST_RUN) && cordic_sts.done
                           && (!m_valid_reg || m_axis_tready);

    // Effective point count: zero acts as one, capped at the index range
    assign count_ext = CW'(point_count_reg);
    assign count_lim = CW'(1) << IW;
    assign count_eff = (count_ext == '0) ? CW'(1)
                     : ((count_ext > count_lim) ? count_lim : count_ext);
    assign idx_plus  = CW'(idx_reg) + CW'(1);
    assign last_pt   = (idx_plus >= count_eff);

    assign idx_wide   = {16'b0, idx_reg};
    assign radius_sum = {1'b0, radius_acc_reg} + 33'(radius_step_reg);

    assign cordic_cmd.start = (state_reg == ST_START);
    assign cordic_cmd.ack   = fin_write;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        radius_acc_next = radius_acc_reg;
        angle_acc_next  = angle_acc_reg;
        m_data_next     = m_data_reg;
        m_last_next     = m_last_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        case (state_reg)
            ST_IDLE:
            begin
                // Take a transaction, restart the spiral if asked
                if (in_xact)
                begin
                    if (s_axis_tdata[0])
                    begin
                        idx_next        = '0;
                        radius_acc_next = start_radius_reg;
                        angle_acc_next  = '0;
                    end
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                // Deliver the point and advance or wrap the accumulators
                if (fin_write)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {idx_wide[15:0], cordic_point.y, cordic_point.x};
                    m_last_next  = last_pt;
                    if (last_pt)
                    begin
                        idx_next        = '0;
                        radius_acc_next = start_radius_reg;
                        angle_acc_next  = '0;
                    end
                    else
                    begin
                        idx_next        = idx_reg + 1'b1;
                        radius_acc_next = radius_sum[32] ? 32'hFFFF_FFFF
                                                         : radius_sum[31:0];
                        angle_acc_next  = angle_acc_reg + angle_step_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            radius_acc_reg <= START_RADIUS_RST;
            angle_acc_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            radius_acc_reg <= radius_acc_next;
            angle_acc_reg  <= angle_acc_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_radius_reg <= START_RADIUS_RST;
            radius_step_reg  <= RADIUS_STEP_RST;
            angle_step_reg   <= ANGLE_STEP_RST;
            point_count_reg  <= POINT_COUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_START_RADIUS: start_radius_reg <= cfg_data;
                REG_RADIUS_STEP:  radius_step_reg  <= cfg_data[23:0];
                REG_ANGLE_STEP:   angle_step_reg   <= cfg_data;
                REG_POINT_COUNT:  point_count_reg  <= cfg_data[16:0];
                default:          ;
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

    `ASG_ASSERT_IMPLY(a_ready_unit_free, s_axis_tready, !cordic_sts.busy)
    `ASG_ASSERT_NEXT(a_accept_starts, in_xact, state_reg == ST_START && cordic_sts.busy == 1'b0)
    `ASG_ASSERT_IMPLY(a_no_overwrite, fin_write, !m_valid_reg || m_axis_tready)
    `ASG_ASSERT_NEXT(a_wrap_clears, fin_write && last_pt, idx_reg == '0 && angle_acc_reg == '0)

endmodule

[rtl/asg_cordic.sv]
module asg_cordic #(
    parameter int STAGES = asg_pkg::CORDIC_STAGES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  asg_pkg::asg_cmd_t  cmd,
    input  logic [31:0]        radius,
    input  logic [31:0]        phase,
    output asg_pkg::asg_sts_t  sts,
    output asg_pkg::asg_point_t point
);
    import asg_pkg::*;

    localparam int XW = 35;                  // x/y datapath, covers gain growth
    localparam int ZW = 33;                  // residual angle
    localparam int SW = $clog2(STAGES);
    localparam logic [SW-1:0] LAST_ITER = SW'(STAGES - 1);

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_PRE  = 2'd1;
    localparam logic [1:0] C_ITER = 2'd2;
    localparam logic [1:0] C_HOLD = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [SW-1:0]        iter_reg, iter_next;
    logic [61:0]          prod_reg, prod_next;
    logic [31:0]          phase_reg, phase_next;
    logic signed [XW-1:0] x_reg, x_next;
    logic signed [XW-1:0] y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;

    logic [61:0]          prod_rnd;
    logic [31:0]          mag;
    logic signed [XW-1:0] mag_s;
    logic [31:0]          phase_adj;
    logic [1:0]           quarter;
    logic [31:0]          resid;
    logic signed [XW-1:0] x_sh, y_sh;
    logic [ATAN_IDX_W-1:0] tab_idx;
    logic signed [ZW-1:0] atan_s;

    // Round half up from Q8.24 to Q7.16 and clamp to 24 bits
    function automatic logic [23:0] sat_q7_16(input logic signed [XW-1:0] v);
        logic signed [XW:0]   t;
        logic signed [XW-8:0] s;
        logic [23:0]          r;
        t = {v[XW-1], v} + (XW+1)'(128);
        s = t[XW:8];
        if (s[XW-8:23] != {(XW-30){s[XW-8]}})
            r = s[XW-8] ? 24'h800000 : 24'h7FFFFF;
        else
            r = s[23:0];
        return r;
    endfunction

    // Scaled radius and quarter-turn fold
    assign prod_rnd  = prod_reg + 62'h2000_0000;
    assign mag       = prod_rnd[61:30];
    assign mag_s     = $signed({{(XW-32){1'b0}}, mag});
    assign phase_adj = phase_reg + 32'h2000_0000;
    assign quarter   = phase_adj[31:30];
    assign resid     = phase_reg - {quarter, 30'b0};

    // Shared shift and add-subtract unit, one micro-rotation per cycle
    assign x_sh    = x_reg >>> iter_reg;
    assign y_sh    = y_reg >>> iter_reg;
    assign tab_idx = ATAN_IDX_W'(iter_reg);
    assign atan_s  = $signed({1'b0, ATAN_TURNS[tab_idx]});

    always_comb
    begin
        state_next = state_reg;
        iter_next  = iter_reg;
        prod_next  = prod_reg;
        phase_next = phase_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        case (state_reg)
            C_IDLE:
            begin
                // Scale the radius by the inverse gain
                if (cmd.start)
                begin
                    prod_next  = {30'b0, radius} * {32'b0, GAIN_INV};
                    phase_next = phase;
                    state_next = C_PRE;
                end
            end
            C_PRE:
            begin
                // Pre-rotate by the nearest quarter turn
                case (quarter)
                    2'd0:
                    begin
                        x_next = mag_s;
                        y_next = '0;
                    end
                    2'd1:
                    begin
                        x_next = '0;
                        y_next = mag_s;
                    end
                    2'd2:
                    begin
                        x_next = -mag_s;
                        y_next = '0;
                    end
                    default:
                    begin
                        x_next = '0;
                        y_next = -mag_s;
                    end
                endcase
                z_next     = $signed({resid[31], resid});
                iter_next  = '0;
                state_next = C_ITER;
            end
            C_ITER:
            begin
                // Rotate toward zero residual
                if (!z_reg[ZW-1])
                begin
                    x_next = x_reg - y_sh;
                    y_next = y_reg + x_sh;
                    z_next = z_reg - atan_s;
                end
                else
                begin
                    x_next = x_reg + y_sh;
                    y_next = y_reg - x_sh;
                    z_next = z_reg + atan_s;
                end
                iter_next = iter_reg + 1'b1;
                if (iter_reg == LAST_ITER)
                    state_next = C_HOLD;
            end
            C_HOLD:
            begin
                // Hold the point until the sequencer takes it
                if (cmd.ack)
                    state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= C_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        iter_reg  <= iter_next;
        prod_reg  <= prod_next;
        phase_reg <= phase_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
    end

    assign sts.busy = (state_reg != C_IDLE);
    assign sts.done = (state_reg == C_HOLD);
    assign point.x  = sat_q7_16(x_reg);
    assign point.y  = sat_q7_16(y_reg);

endmodule

[sim/tb_archimedean_spiral_generator.sv]
module tb_archimedean_spiral_generator;
    timeunit 1ns;
    timeprecision 1ps;

    // Rotation unit depth of the instance (block default) and bench limits
    localparam int ROT_STAGES   = asg_pkg::CORDIC_STAGES_DEF;
    localparam int ROT_TABLE_LEN = 30;
    localparam int POINT_LATENCY = ROT_STAGES + 4;
    localparam int SETTLE_CYCLES = POINT_LATENCY + 16;
    localparam int MAX_PRINTED   = 40;

    // round(2^30 / K), K the gain of an endless rotation chain
    localparam logic [63:0] SCALE_GAIN = 64'd652032874;

    // Micro-rotation angles, full turn = 2^32
    localparam longint ROT_ANGLES [ROT_TABLE_LEN] = '{
        'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43,
        'h0145D7E1, 'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F,
        'h000A2F98, 'h000517CC, 'h00028BE6, 'h000145F3, 'h0000A2FA,
        'h0000517D, 'h000028BE, 'h0000145F, 'h00000A30, 'h00000518,
        'h0000028C, 'h00000146, 'h000000A3, 'h00000051, 'h00000029,
        'h00000014, 'h0000000A, 'h00000005, 'h00000003, 'h00000001
    };

    typedef struct packed {
        logic [23:0] x_coord;
        logic [23:0] y_coord;
        logic [15:0] point_index;
        logic        last_point;
    } spiral_point_t;

    logic                                clk;
    logic                                rst_n          = 1'b0;
    logic                                s_axis_tvalid  = 1'b0;
    logic                                s_axis_tready;
    logic [7:0]                          s_axis_tdata   = 8'd0;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready  = 1'b0;
    logic [63:0]                         m_axis_tdata;
    logic                                m_axis_tlast;
    logic                                cfg_valid      = 1'b0;
    logic                                cfg_ready;
    logic [asg_pkg::CFG_INDEX_WIDTH-1:0] cfg_index      = asg_pkg::REG_START_RADIUS;
    logic [31:0]                         cfg_data       = 32'd0;

    // Register copies, as the block holds them
    logic [31:0] reg_start_radius = 32'd16777216;
    logic [23:0] reg_radius_step  = 24'd8389;
    logic [31:0] reg_angle_step   = 32'd536871;
    logic [16:0] reg_point_count  = 17'd32768;

    // Spiral position of the next point
    logic [15:0] trk_index  = 16'd0;
    logic [31:0] trk_radius = 32'd16777216;
    logic [31:0] trk_phase  = 32'd0;

    spiral_point_t pending_points [$];
    int            mismatch_count = 0;
    int            src_idle_pct   = 0;
    int            sink_idle_pct  = 0;

    archimedean_spiral_generator u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Round Q8.24 to Q7.16 and clamp to 24 signed bits
    function automatic logic [23:0] round_q716(input longint v);
        longint r;
        r = (v + 128) >>> 8;
        if (r > 8388607)
            r = 8388607;
        else if (r < -8388608)
            r = -8388608;
        return r[23:0];
    endfunction

    // Rotate (radius, 0) by the phase: quarter-turn fold, then micro-rotations
    function automatic void rotate_radius(input logic [31:0] radius, input logic [31:0] phase,
                                          output logic [23:0] x_out, output logic [23:0] y_out);
        logic [63:0] scaled;
        logic [31:0] folded;
        logic [1:0]  quarter;
        logic [31:0] resid;
        longint      m, x, y, z, dx, dy;
        int          i;
        scaled  = {32'd0, radius} * SCALE_GAIN + (64'd1 << 29);
        m       = longint'(scaled >> 30);
        folded  = phase + 32'h2000_0000;
        quarter = folded[31:30];
        resid   = phase - {quarter, 30'd0};
        z       = longint'($signed(resid));
        case (quarter)
            2'd0:    begin x = m;  y = 0;  end
            2'd1:    begin x = 0;  y = m;  end
            2'd2:    begin x = -m; y = 0;  end
            default: begin x = 0;  y = -m; end
        endcase
        for (i = 0; i < ROT_STAGES && i < ROT_TABLE_LEN; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - ROT_ANGLES[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + ROT_ANGLES[i];
            end
        end
        x_out = round_q716(x);
        y_out = round_q716(y);
    endfunction

    // Produce the point for one tick and advance the spiral
    function automatic spiral_point_t next_spiral_point(input logic restart);
        spiral_point_t pt;
        int unsigned   n_points;
        logic [32:0]   grown;
        if (restart)
        begin
            trk_index  = 16'd0;
            trk_radius = reg_start_radius;
            trk_phase  = 32'd0;
        end
        n_points = 32'(reg_point_count);
        if (n_points == 0)
            n_points = 1;
        else if (n_points > 65536)
            n_points = 65536;
        rotate_radius(trk_radius, trk_phase, pt.x_coord, pt.y_coord);
        pt.point_index = trk_index;
        pt.last_point  = (32'(trk_index) + 1 >= n_points);
        if (pt.last_point)
        begin
            trk_index  = 16'd0;
            trk_radius = reg_start_radius;
            trk_phase  = 32'd0;
        end
        else
        begin
            grown      = {1'b0, trk_radius} + {9'd0, reg_radius_step};
            trk_index  = trk_index + 16'd1;
            trk_radius = grown[32] ? 32'hFFFF_FFFF : grown[31:0];
            trk_phase  = trk_phase + reg_angle_step;
        end
        return pt;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_PRINTED)
            $display("%0t ns: mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // Track register writes and predict a point for every accepted tick
    always @(posedge clk)
    begin : track_spiral
        spiral_point_t predicted;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    asg_pkg::REG_START_RADIUS: reg_start_radius = cfg_data;
                    asg_pkg::REG_RADIUS_STEP:  reg_radius_step  = cfg_data[23:0];
                    asg_pkg::REG_ANGLE_STEP:   reg_angle_step   = cfg_data;
                    asg_pkg::REG_POINT_COUNT:  reg_point_count  = cfg_data[16:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                predicted      = next_spiral_point(s_axis_tdata[0]);
                pending_points = {pending_points, predicted};
            end
        end
    end

    // Compare each output transaction with the oldest predicted point
    always @(posedge clk)
    begin : check_points
        spiral_point_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_points.size() == 0)
                report_mismatch($sformatf("point with none pending, tdata %h", m_axis_tdata));
            else
            begin
                want = pending_points.pop_front();
                if (m_axis_tdata[23:0] !== want.x_coord)
                    report_mismatch($sformatf("point %0d x_coord got %h want %h",
                                              want.point_index, m_axis_tdata[23:0],
                                              want.x_coord));
                if (m_axis_tdata[47:24] !== want.y_coord)
                    report_mismatch($sformatf("point %0d y_coord got %h want %h",
                                              want.point_index, m_axis_tdata[47:24],
                                              want.y_coord));
                if (m_axis_tdata[63:48] !== want.point_index)
                    report_mismatch($sformatf("point_index got %0d want %0d",
                                              m_axis_tdata[63:48], want.point_index));
                if (m_axis_tlast !== want.last_point)
                    report_mismatch($sformatf("point %0d last_point got %b want %b",
                                              want.point_index, m_axis_tlast,
                                              want.last_point));
            end
        end
    end

    // Stall the output at random
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);

    // Send one tick, with a random gap ahead of it; valid stays high after acceptance
    task automatic send_point(input logic restart);
        if ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, restart};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Drop valid, let the last accepted tick be predicted, then wait for every point
    task automatic drain_points();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_points.size() != 0)
            @(posedge clk);
    endtask

    // Write all four registers back to back; the block is idle here
    task automatic load_config(input logic [31:0] start_radius, input logic [31:0] radius_step,
                               input logic [31:0] angle_step, input logic [31:0] point_count);
        logic [asg_pkg::CFG_INDEX_WIDTH-1:0] reg_ids [4];
        logic [31:0]                         values  [4];
        reg_ids = '{asg_pkg::REG_START_RADIUS, asg_pkg::REG_RADIUS_STEP,
                    asg_pkg::REG_ANGLE_STEP, asg_pkg::REG_POINT_COUNT};
        values  = '{start_radius, radius_step, angle_step, point_count};
        for (int k = 0; k < 4; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= reg_ids[k];
            cfg_data  <= values[k];
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    // Points from the reset state and reset registers
    task automatic test_reset_defaults();
        repeat (3)
            send_point(1'b0);
    endtask

    // Short spiral: wrap at the count, restart mid-spiral, zero count
    task automatic test_count_and_restart();
        drain_points();
        load_config(32'h0080_0000, 32'hA510_0000, 32'h1000_0000, 32'hFFFE_0003);
        send_point(1'b1);
        repeat (4)
            send_point(1'b0);
        send_point(1'b1);
        send_point(1'b0);
        drain_points();
        // A zero count makes every point the last
        load_config(32'h0000_0000, 32'h00FF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        send_point(1'b0);
        send_point(1'b0);
    endtask

    // Largest radius: coordinates clamp and the radius holds at its top
    task automatic test_saturation();
        drain_points();
        load_config(32'hFFFF_FFFF, 32'h00FF_FFFF, 32'h2000_0000, 32'h0001_0001);
        send_point(1'b1);
        repeat (3)
            send_point(1'b0);
    endtask

    // Eighth-turn steps walk all quadrants and the fold boundaries
    task automatic test_quadrants();
        drain_points();
        load_config(32'h0400_0000, 32'h0000_0000, 32'h2000_0000, 32'h0001_FFFF);
        send_point(1'b1);
        repeat (8)
            send_point(1'b0);
    endtask

    // Random register settings with bursts of ticks, restarts now and then
    task automatic test_random_spirals(input int n_items, input int src_pct, input int sink_pct);
        int          sent;
        int          burst;
        logic [31:0] start_r, r_step, a_step, count;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        sent = 0;
        while (sent < n_items)
        begin
            case ($urandom_range(4))
                0:       start_r = 32'd0;
                1:       start_r = 32'hFFFF_FFFF;
                2:       start_r = $urandom;
                default: start_r = $urandom_range(32'h0800_0000);
            endcase
            r_step = $urandom;
            case ($urandom_range(3))
                0:       r_step[23:0] = 24'd0;
                1:       r_step[23:0] = 24'hFF_FFFF;
                2:       r_step[23:0] = 24'($urandom_range(32'h0004_0000));
                default: ;
            endcase
            case ($urandom_range(4))
                0:       a_step = 32'd0;
                1:       a_step = 32'hFFFF_FFFF;
                2:       a_step = $urandom_range(32'h0800_0000);
                default: a_step = $urandom;
            endcase
            count = $urandom;
            case ($urandom_range(7))
                0:       count[16:0] = 17'd0;
                1:       count[16:0] = 17'd1;
                2:       count[16:0] = 17'd65536;
                3:       count[16:0] = 17'($urandom_range(131071, 65537));
                4:       count[16:0] = 17'($urandom_range(200, 41));
                default: count[16:0] = 17'($urandom_range(40, 2));
            endcase
            drain_points();
            load_config(start_r, r_step, a_step, count);
            burst = $urandom_range(90, 20);
            for (int k = 0; k < burst && sent < n_items; k++)
            begin
                send_point($urandom_range(15) == 0);
                sent++;
            end
        end
    endtask

    initial
    begin
        src_idle_pct  = 24;
        sink_idle_pct = 65;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_count_and_restart();
        test_saturation();
        test_quadrants();
        test_random_spirals(650, 24, 65);
        test_random_spirals(650, 65, 24);
        test_random_spirals(650, 0, 0);

        // Let any stray output transaction show up
        drain_points();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (mismatch_count == 0 && pending_points.size() == 0)
            $display("tb_archimedean_spiral_generator: PASS");
        else
            $display("tb_archimedean_spiral_generator: FAIL");
        $finish;
    end

    // Watchdog: fails the run if it has not finished in time
    initial
    begin
        #4_000_000;
        $display("tb_archimedean_spiral_generator: FAIL");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/asg_pkg.sv
rtl/asg_cordic.sv
rtl/archimedean_spiral_generator.sv
sim/tb_archimedean_spiral_generator.sv
